// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define MCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/mcs_pkg.sv =====
// Types, constants and the Morse lookup shared by the sequencer files.
package mcs_pkg;

    localparam int MAX_SYMBOLS_DEF = 5;

    localparam int CHAR_W   = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int TOG_W    = 9;
    localparam int HALF_W   = 16;
    localparam int WAIT_W   = 19;
    localparam int PAT_W    = 5;
    localparam int LEN_W    = 3;

    localparam logic [7:0]  TOGGLES_RESET = 8'd75;
    localparam logic [15:0] HALF_RESET    = 16'd500;
    localparam logic [15:0] GAP_RESET     = 16'd15000;

    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP     = 2'd2;

    typedef enum logic [1:0] {
        KIND_TONE    = 2'd0,
        KIND_SILENCE = 2'd1,
        KIND_HOLD    = 2'd2
    } seg_kind_t;

    typedef enum logic [1:0] {
        LED_OFF    = 2'd0,
        LED_RED    = 2'd1,
        LED_YELLOW = 2'd2,
        LED_GREEN  = 2'd3
    } led_t;

    typedef enum logic [1:0] {
        SEL_TONE,
        SEL_SYM_GAP,
        SEL_CHAR_GAP,
        SEL_HOLD
    } seg_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TONE,
        ST_SYM_GAP,
        ST_CHAR_GAP,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic     load;
        logic     emit;
        seg_sel_t sel;
        logic     last;
        logic     next_sym;
    } cmd_t;

    typedef struct packed {
        logic in_has_sym;
        logic sym_more;
        logic eom;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic             found;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
    } morse_entry_t;

    // {length, pattern}; pattern bit i is set when symbol i is a dash.
    localparam logic [7:0] MORSE_TABLE [0:35] = '{
        8'b010_00010, 8'b100_00001, 8'b100_00101, 8'b011_00001, 8'b001_00000,
        8'b100_00100, 8'b011_00011, 8'b100_00000, 8'b010_00000, 8'b100_01110,
        8'b011_00101, 8'b100_00010, 8'b010_00011, 8'b010_00001, 8'b011_00111,
        8'b100_00110, 8'b100_01011, 8'b011_00010, 8'b011_00000, 8'b001_00001,
        8'b011_00100, 8'b100_01000, 8'b011_00110, 8'b100_01001, 8'b100_01101,
        8'b100_00011,
        8'b101_11111, 8'b101_11110, 8'b101_11100, 8'b101_11000, 8'b101_10000,
        8'b101_00000, 8'b101_00001, 8'b101_00011, 8'b101_00111, 8'b101_01111
    };

    function automatic morse_entry_t char_to_morse(input logic [CHAR_W-1:0] ch);
        morse_entry_t e;
        logic [5:0]   idx;
        logic [7:0]   raw;
        e   = '0;
        idx = '0;
        if (ch inside {[8'h41:8'h5A]})
        begin
            idx     = 6'(ch - 8'h41);
            e.found = 1'b1;
        end
        else if (ch inside {[8'h61:8'h7A]})
        begin
            idx     = 6'(ch - 8'h61);
            e.found = 1'b1;
        end
        else if (ch inside {[8'h30:8'h39]})
        begin
            idx     = 6'(ch - 8'h30) + 6'd26;
            e.found = 1'b1;
        end
        raw = MORSE_TABLE[idx];
        if (e.found)
        begin
            e.len = raw[7:5];
            e.pat = raw[4:0];
        end
        return e;
    endfunction

endpackage

// ===== rtl/core/mcs_if.sv =====
// Valid/ready channels for characters in and playback segments out.
interface mcs_char_if;
    logic                        valid;
    logic                        ready;
    logic [mcs_pkg::CHAR_W-1:0]  char_code;
    logic                        end_of_message;

    modport source (output valid, output char_code, output end_of_message, input ready);
    modport sink   (input valid, input char_code, input end_of_message, output ready);
endinterface

interface mcs_seg_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  segment_kind;
    logic [1:0]                  led_color;
    logic [mcs_pkg::TOG_W-1:0]   toggle_count;
    logic [mcs_pkg::HALF_W-1:0]  half_period;
    logic [mcs_pkg::WAIT_W-1:0]  wait_count;
    logic                        last_of_run;

    modport source (output valid, output segment_kind, output led_color,
                    output toggle_count, output half_period, output wait_count,
                    output last_of_run, input ready);
    modport sink   (input valid, input segment_kind, input led_color,
                    input toggle_count, input half_period, input wait_count,
                    input last_of_run, output ready);
endinterface

// ===== rtl/core/mcs_datapath.sv =====
// Datapath: config registers, character lookup, symbol walk and output register.
module mcs_datapath #(
    parameter int MAX_SYMBOLS = mcs_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            write_enable,
    input  logic [mcs_pkg::CFG_IDX_W-1:0]   write_index,
    input  logic [mcs_pkg::CFG_W-1:0]       write_data,
    input  logic [mcs_pkg::CHAR_W-1:0]      char_code,
    input  logic                            end_of_message,
    input  mcs_pkg::cmd_t                   cmd,
    output mcs_pkg::status_t                status,
    input  logic                            seg_ready,
    output logic                            seg_valid,
    output logic [1:0]                      segment_kind,
    output logic [1:0]                      led_color,
    output logic [mcs_pkg::TOG_W-1:0]       toggle_count,
    output logic [mcs_pkg::HALF_W-1:0]      half_period,
    output logic [mcs_pkg::WAIT_W-1:0]      wait_count,
    output logic                            last_of_run
);
    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam int IDX_W = $clog2(MAX_SYMBOLS);

    logic [7:0]                 toggles_reg;
    logic [15:0]                half_reg;
    logic [15:0]                gap_reg;

    logic [MAX_SYMBOLS-1:0]     pat_reg;
    logic [CNT_W-1:0]           total_reg;
    logic [CNT_W-1:0]           idx_reg;
    logic                       eom_reg;

    logic                       valid_reg, valid_next;
    logic [1:0]                 kind_reg, kind_next;
    logic [1:0]                 led_reg, led_next;
    logic [mcs_pkg::TOG_W-1:0]  tog_reg, tog_next;
    logic [mcs_pkg::HALF_W-1:0] halfp_reg, halfp_next;
    logic [mcs_pkg::WAIT_W-1:0] wait_reg, wait_next;
    logic                       last_reg;

    mcs_pkg::morse_entry_t      entry;
    logic [CNT_W-1:0]           len_ext;
    logic [CNT_W-1:0]           total_new;
    logic                       dash;

    assign entry     = mcs_pkg::char_to_morse(char_code);
    assign len_ext   = CNT_W'(entry.len);
    assign total_new = (len_ext > CNT_W'(MAX_SYMBOLS)) ? CNT_W'(MAX_SYMBOLS) : len_ext;
    assign dash      = pat_reg[idx_reg[IDX_W-1:0]];

    assign status.in_has_sym = entry.found;
    assign status.sym_more   = (idx_reg + CNT_W'(1)) < total_reg;
    assign status.eom        = eom_reg;
    assign status.out_free   = !valid_reg || seg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggles_reg <= mcs_pkg::TOGGLES_RESET;
            half_reg    <= mcs_pkg::HALF_RESET;
            gap_reg     <= mcs_pkg::GAP_RESET;
        end
        else if (write_enable)
        begin
            case (write_index)
                mcs_pkg::CFG_TOGGLES: toggles_reg <= write_data[7:0];
                mcs_pkg::CFG_HALF:    half_reg    <= write_data;
                mcs_pkg::CFG_GAP:     gap_reg     <= write_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg   <= '0;
            total_reg <= '0;
            idx_reg   <= '0;
            eom_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            pat_reg   <= MAX_SYMBOLS'(entry.pat);
            total_reg <= total_new;
            idx_reg   <= '0;
            eom_reg   <= end_of_message;
        end
        else if (cmd.next_sym)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        kind_next  = mcs_pkg::KIND_SILENCE;
        led_next   = mcs_pkg::LED_OFF;
        tog_next   = '0;
        halfp_next = '0;
        wait_next  = '0;
        case (cmd.sel)
            mcs_pkg::SEL_TONE:
            begin
                kind_next  = mcs_pkg::KIND_TONE;
                led_next   = dash ? mcs_pkg::LED_YELLOW : mcs_pkg::LED_RED;
                tog_next   = dash ? {toggles_reg, 1'b0} : {1'b0, toggles_reg};
                halfp_next = half_reg;
            end
            mcs_pkg::SEL_SYM_GAP:  wait_next = {3'b000, gap_reg};
            mcs_pkg::SEL_CHAR_GAP: wait_next = {2'b00, gap_reg, 1'b0};
            mcs_pkg::SEL_HOLD:
            begin
                kind_next = mcs_pkg::KIND_HOLD;
                led_next  = mcs_pkg::LED_GREEN;
                wait_next = {gap_reg, 3'b000};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.emit)
            valid_next = 1'b1;
        else if (seg_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg  <= kind_next;
            led_reg   <= led_next;
            tog_reg   <= tog_next;
            halfp_reg <= halfp_next;
            wait_reg  <= wait_next;
            last_reg  <= cmd.last;
        end
    end

    assign seg_valid    = valid_reg;
    assign segment_kind = kind_reg;
    assign led_color    = led_reg;
    assign toggle_count = tog_reg;
    assign half_period  = halfp_reg;
    assign wait_count   = wait_reg;
    assign last_of_run  = last_reg;
endmodule

// ===== rtl/core/mcs_controller.sv =====
// Controller: walks one character through tone, gap and hold segments.
module mcs_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mcs_pkg::status_t   status,
    output mcs_pkg::cmd_t      cmd
);
    mcs_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mcs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.emit     = 1'b0;
        cmd.sel      = mcs_pkg::SEL_TONE;
        cmd.last     = 1'b0;
        cmd.next_sym = 1'b0;
        case (state_reg)
            mcs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.in_has_sym ? mcs_pkg::ST_TONE
                                                   : mcs_pkg::ST_CHAR_GAP;
                end
            end
            mcs_pkg::ST_TONE:
            begin
                cmd.sel = mcs_pkg::SEL_TONE;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = mcs_pkg::ST_SYM_GAP;
                end
            end
            mcs_pkg::ST_SYM_GAP:
            begin
                cmd.sel = mcs_pkg::SEL_SYM_GAP;
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.sym_more)
                    begin
                        cmd.next_sym = 1'b1;
                        state_next   = mcs_pkg::ST_TONE;
                    end
                    else
                        state_next = mcs_pkg::ST_CHAR_GAP;
                end
            end
            mcs_pkg::ST_CHAR_GAP:
            begin
                cmd.sel  = mcs_pkg::SEL_CHAR_GAP;
                cmd.last = !status.eom;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.eom ? mcs_pkg::ST_HOLD : mcs_pkg::ST_IDLE;
                end
            end
            mcs_pkg::ST_HOLD:
            begin
                cmd.sel  = mcs_pkg::SEL_HOLD;
                cmd.last = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = mcs_pkg::ST_IDLE;
                end
            end
            default: state_next = mcs_pkg::ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/core/morse_character_sequencer.sv =====
// Top level of the Morse character sequencer: controller, datapath and checks.
`include "assert_macros.svh"

// Takes one ASCII character per word on char_in and plays it out as International
// Morse playback segments on seg_out. Letters of either case and digits are sent;
// any other code sends only the character gap. Each dot or dash gives a tone
// segment (red LED and toggles_per_unit toggles for a dot, yellow LED and twice
// that for a dash, each at the programmed half period) followed by a silence of
// unit_gap; then a silence of 2 * unit_gap ends the character, and with
// end_of_message set a green hold of 8 * unit_gap follows. last_of_run marks the
// final segment of a character. A character with S symbols makes 2*S+1 segments
// (one more with the hold). The single output register paces this: the
// controller issues one segment into it per cycle while the output register is
// free (seg_out is not stalling it), and the next character is accepted in the
// cycle after the last segment enters that register. Configuration (write_index 0
// toggles_per_unit, 1 the tone half period, 2 unit_gap; index 3 is dropped)
// must be written only while no character is in flight.
module morse_character_sequencer #(
    parameter int MAX_SYMBOLS = mcs_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    mcs_char_if.sink                       char_in,
    mcs_seg_if.source                      seg_out,
    input  logic                           write_enable,
    input  logic [mcs_pkg::CFG_IDX_W-1:0]  write_index,
    input  logic [mcs_pkg::CFG_W-1:0]      write_data
);
    // Command and status between the sequencing FSM and the datapath.
    mcs_pkg::cmd_t    cmd;
    mcs_pkg::status_t status;
    logic             in_ready;

    // Shorthand terms for the checks at the end.
    logic             char_take;
    logic             is_hold;
    logic             hold_ok;
    logic             is_tone;
    logic             tone_ok;

    mcs_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (char_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Ready comes only from the FSM being idle; the datapath holds the last
    // segment until seg_out takes it.
    assign char_in.ready = in_ready;

    mcs_datapath #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .write_enable   (write_enable),
        .write_index    (write_index),
        .write_data     (write_data),
        .char_code      (char_in.char_code),
        .end_of_message (char_in.end_of_message),
        .cmd            (cmd),
        .status         (status),
        .seg_ready      (seg_out.ready),
        .seg_valid      (seg_out.valid),
        .segment_kind   (seg_out.segment_kind),
        .led_color      (seg_out.led_color),
        .toggle_count   (seg_out.toggle_count),
        .half_period    (seg_out.half_period),
        .wait_count     (seg_out.wait_count),
        .last_of_run    (seg_out.last_of_run)
    );

    assign char_take = char_in.valid && char_in.ready;
    assign is_hold   = seg_out.valid && (seg_out.segment_kind == mcs_pkg::KIND_HOLD);
    assign hold_ok   = seg_out.last_of_run && (seg_out.led_color == mcs_pkg::LED_GREEN);
    assign is_tone   = seg_out.valid && (seg_out.segment_kind == mcs_pkg::KIND_TONE);
    assign tone_ok   = (seg_out.led_color inside {mcs_pkg::LED_RED, mcs_pkg::LED_YELLOW})
                       && (seg_out.wait_count == '0) && !seg_out.last_of_run;

    // A character always produces at least one segment, so the block is busy
    // the cycle after it takes a word.
    `MCS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, char_take, !char_in.ready)

    // The green hold is always the final segment of its character.
    `MCS_ASSERT_IMPL(a_hold_is_last, clk, rst_n, is_hold, hold_ok)

    // Tone segments light red or yellow and carry no wait count.
    `MCS_ASSERT_IMPL(a_tone_fields, clk, rst_n, is_tone, tone_ok)

    // The FSM never issues a segment while a stalled one still sits in the register.
    `MCS_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.emit, status.out_free)
endmodule

// ===== sim/morse_segment_checker.sv =====
// Checker for the Morse sequencer: predicts playback segments per character and compares.
`timescale 1ns / 1ps

module morse_segment_checker #(
    parameter int MAX_SYMBOLS = mcs_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    mcs_char_if                            char_mon,
    mcs_seg_if                             seg_mon,
    input  logic                           write_enable,
    input  logic [mcs_pkg::CFG_IDX_W-1:0]  write_index,
    input  logic [mcs_pkg::CFG_W-1:0]      write_data,
    output int                             expected_left,
    output int                             error_count
);

    import mcs_pkg::*;

    typedef struct packed {
        seg_kind_t          kind;
        led_t               led;
        logic [TOG_W-1:0]   toggles;
        logic [HALF_W-1:0]  half;
        logic [WAIT_W-1:0]  wait_cnt;
        logic               last;
    } segment_t;

    // Dots and dashes for A..Z, then 0..9
    string morse_codes [0:35] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-",
        ".....", "-....", "--...", "---..", "----."
    };

    segment_t        segments_due [$];
    logic [7:0]      toggles_cfg;
    logic [15:0]     half_cfg;
    logic [15:0]     gap_cfg;
    int              segments_seen;

    task automatic report_mismatch(input string msg);
        $display("%0t: segment %0d: %s", $time, segments_seen, msg);
        error_count++;
    endtask

    // Queue the segments one character causes under the current settings.
    function automatic void queue_segments_for_char(input logic [7:0] ch, input logic eom);
        string    code;
        segment_t seg;
        int       n_sym;
        bit       dash;
        code = "";
        if (ch >= 8'h41 && ch <= 8'h5A)
            code = morse_codes[ch - 8'h41];
        else if (ch >= 8'h61 && ch <= 8'h7A)
            code = morse_codes[ch - 8'h61];
        else if (ch >= 8'h30 && ch <= 8'h39)
            code = morse_codes[ch - 8'h30 + 26];
        n_sym = code.len();
        if (n_sym > MAX_SYMBOLS)
            n_sym = MAX_SYMBOLS;
        for (int i = 0; i < n_sym; i++)
        begin
            dash         = (code[i] == "-");
            seg          = '0;
            seg.kind     = KIND_TONE;
            seg.led      = dash ? LED_YELLOW : LED_RED;
            seg.toggles  = dash ? {toggles_cfg, 1'b0} : {1'b0, toggles_cfg};
            seg.half     = half_cfg;
            segments_due.push_back(seg);
            seg          = '0;
            seg.kind     = KIND_SILENCE;
            seg.led      = LED_OFF;
            seg.wait_cnt = {3'b000, gap_cfg};
            segments_due.push_back(seg);
        end
        seg          = '0;
        seg.kind     = KIND_SILENCE;
        seg.led      = LED_OFF;
        seg.wait_cnt = {2'b00, gap_cfg, 1'b0};
        seg.last     = !eom;
        segments_due.push_back(seg);
        if (eom)
        begin
            seg          = '0;
            seg.kind     = KIND_HOLD;
            seg.led      = LED_GREEN;
            seg.wait_cnt = {gap_cfg, 3'b000};
            seg.last     = 1'b1;
            segments_due.push_back(seg);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        segment_t want;
        if (!rst_n)
        begin
            segments_due.delete();
            toggles_cfg   = TOGGLES_RESET;
            half_cfg      = HALF_RESET;
            gap_cfg       = GAP_RESET;
            segments_seen = 0;
            error_count   = 0;
            expected_left = 0;
        end
        else
        begin
            if (write_enable)
            begin
                case (write_index)
                    CFG_TOGGLES: toggles_cfg = write_data[7:0];
                    CFG_HALF:    half_cfg    = write_data;
                    CFG_GAP:     gap_cfg     = write_data;
                    default:     ;
                endcase
            end
            if (seg_mon.valid && seg_mon.ready)
            begin
                if (segments_due.size() == 0)
                    report_mismatch($sformatf("no segment expected, got kind %0d wait %0d",
                                              seg_mon.segment_kind, seg_mon.wait_count));
                else
                begin
                    want = segments_due.pop_front();
                    if (seg_mon.segment_kind !== want.kind)
                        report_mismatch($sformatf("segment_kind %0d, expected %0d",
                                                  seg_mon.segment_kind, want.kind));
                    if (seg_mon.led_color !== want.led)
                        report_mismatch($sformatf("led_color %0d, expected %0d",
                                                  seg_mon.led_color, want.led));
                    if (seg_mon.toggle_count !== want.toggles)
                        report_mismatch($sformatf("toggle_count %0d, expected %0d",
                                                  seg_mon.toggle_count, want.toggles));
                    if (seg_mon.half_period !== want.half)
                        report_mismatch($sformatf("half_period %0d, expected %0d",
                                                  seg_mon.half_period, want.half));
                    if (seg_mon.wait_count !== want.wait_cnt)
                        report_mismatch($sformatf("wait_count %0d, expected %0d",
                                                  seg_mon.wait_count, want.wait_cnt));
                    if (seg_mon.last_of_run !== want.last)
                        report_mismatch($sformatf("last_of_run %0d, expected %0d",
                                                  seg_mon.last_of_run, want.last));
                end
                segments_seen++;
            end
            // Output words of a character can never leave in the cycle it is taken
            if (char_mon.valid && char_mon.ready)
                queue_segments_for_char(char_mon.char_code, char_mon.end_of_message);
            expected_left = segments_due.size();
        end
    end

endmodule

// ===== sim/morse_character_sequencer_test.sv =====
// Top of the Morse sequencer testbench: clock, reset, character stimulus and verdict.
`timescale 1ns / 1ps

module morse_character_sequencer_test;

    import mcs_pkg::*;

    // Index past the register list; the block must drop writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Opening words: {end_of_message, char_code}. Cover both letter cases at
    // the range ends, digits, one-symbol letters, five-symbol digits with the
    // hold (the longest run), and codes just outside every letter and digit range.
    localparam logic [8:0] OPENING_CHARS [0:21] = '{
        {1'b0, 8'h41}, {1'b0, 8'h5A}, {1'b0, 8'h61}, {1'b1, 8'h7A},
        {1'b0, 8'h30}, {1'b1, 8'h39}, {1'b1, 8'h35}, {1'b0, 8'h54},
        {1'b0, 8'h45}, {1'b0, 8'h00}, {1'b1, 8'hFF}, {1'b0, 8'h40},
        {1'b0, 8'h5B}, {1'b0, 8'h60}, {1'b0, 8'h7B}, {1'b0, 8'h2F},
        {1'b1, 8'h3A}, {1'b0, 8'h51}, {1'b0, 8'h79}, {1'b1, 8'h31},
        {1'b0, 8'h80}, {1'b0, 8'h7F}
    };

    localparam int PHASES          = 6;
    localparam int WORDS_PER_PHASE = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  write_enable;
    logic [CFG_IDX_W-1:0]  write_index;
    logic [CFG_W-1:0]      write_data;
    int                    expected_left;
    int                    error_count;
    bit                    calm_mode;

    mcs_char_if char_bus ();
    mcs_seg_if  seg_bus ();

    morse_character_sequencer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_in      (char_bus),
        .seg_out      (seg_bus),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data)
    );

    morse_segment_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_mon      (char_bus),
        .seg_mon       (seg_bus),
        .write_enable  (write_enable),
        .write_index   (write_index),
        .write_data    (write_data),
        .expected_left (expected_left),
        .error_count   (error_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle stretch length: mostly a few cycles, now and then a long one.
    function automatic int idle_length();
        if ($urandom_range(0, 19) < 16)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // Mostly real characters so most words play symbols; the rest is any byte.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'($urandom_range(8'h41, 8'h5A));
        if (r < 60)
            return 8'($urandom_range(8'h61, 8'h7A));
        if (r < 80)
            return 8'($urandom_range(8'h30, 8'h39));
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one character word and hold it until the block takes it. Called at
    // a falling edge; returns at the falling edge after the handshake. valid
    // stays high across back-to-back words unless a random idle gap comes first.
    task automatic send_char(input logic [7:0] ch, input logic eom);
        int gap;
        gap = 0;
        if (!calm_mode && $urandom_range(0, 2) == 0)
            gap = idle_length();
        if (gap > 0)
        begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_bus.valid          <= 1'b1;
        char_bus.char_code      <= ch;
        char_bus.end_of_message <= eom;
        do
            @(posedge clk);
        while (!char_bus.ready);
        @(negedge clk);
    endtask

    // Drop valid and hold until every predicted segment has come out. Every
    // character causes at least one segment, so an empty store means idle;
    // a final wait covers the output register settling.
    task automatic drain_segments();
        char_bus.valid <= 1'b0;
        while (expected_left != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all three registers back to back, then poke the spare index with
    // junk. Upper bits of the toggle word are random: only the low byte counts.
    task automatic program_registers(input logic [7:0] toggles, input logic [15:0] half,
                                     input logic [15:0] gap);
        write_enable <= 1'b1;
        write_index  <= CFG_TOGGLES;
        write_data   <= {8'($urandom), toggles};
        @(negedge clk);
        write_index  <= CFG_HALF;
        write_data   <= half;
        @(negedge clk);
        write_index  <= CFG_GAP;
        write_data   <= gap;
        @(negedge clk);
        write_index  <= CFG_SPARE;
        write_data   <= 16'($urandom);
        @(negedge clk);
        write_enable <= 1'b0;
    endtask

    // Output side: take segment words with random stalls, none started in calm phases.
    initial
    begin
        int stall_left;
        stall_left    = 0;
        seg_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && !calm_mode && $urandom_range(0, 3) == 0)
                stall_left = idle_length();
            if (stall_left > 0)
            begin
                seg_bus.ready <= 1'b0;
                stall_left--;
            end
            else
                seg_bus.ready <= 1'b1;
        end
    end

    // Stimulus and verdict
    initial
    begin
        int k;
        rst_n                   = 1'b0;
        calm_mode               = 1'b0;
        char_bus.valid          = 1'b0;
        char_bus.char_code      = '0;
        char_bus.end_of_message = 1'b0;
        write_enable            = 1'b0;
        write_index             = '0;
        write_data              = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words under the reset settings
        foreach (OPENING_CHARS[i])
            send_char(OPENING_CHARS[i][7:0], OPENING_CHARS[i][8]);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_segments();
            case (phase)
                0: program_registers(8'hFF, 16'hFFFF, 16'hFFFF);
                1: program_registers(8'h00, 16'h0000, 16'h0000);
                2: program_registers(8'h01, 16'h0001, 16'h0001);
                3: program_registers(8'($urandom), 16'($urandom), 16'($urandom));
                4: program_registers(8'($urandom_range(1, 255)), 16'($urandom),
                                     16'($urandom_range(1, 300)));
                default: program_registers(TOGGLES_RESET, HALF_RESET, GAP_RESET);
            endcase
            // One phase runs with no idling on either side
            calm_mode = (phase == 4);
            for (k = 0; k < WORDS_PER_PHASE; k++)
            begin
                // Hold the sender mid-phase until the output side catches up
                if (k == WORDS_PER_PHASE / 2)
                    drain_segments();
                send_char(pick_char(), $urandom_range(0, 3) == 0);
            end
        end

        drain_segments();
        // Give any stray segment time to show up
        repeat (30) @(negedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard stop if the handshakes hang
    initial
    begin
        #(50_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mcs_pkg.sv
rtl/core/mcs_if.sv
rtl/core/mcs_datapath.sv
rtl/core/mcs_controller.sv
rtl/core/morse_character_sequencer.sv
sim/morse_segment_checker.sv
sim/morse_character_sequencer_test.sv
